// ===== rtl/krt_pkg.sv =====
// Shared types, constants and helpers of the keyed record table.
package krt_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int PHONE_W  = 34;
  localparam int HEAD_W   = 64;
  localparam int TAIL_W   = 8;
  localparam int STR_W    = HEAD_W + TAIL_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 3'd0,
    CMD_DEL  = 3'd1,
    CMD_LIST = 3'd2,
    CMD_NUM  = 3'd3,
    CMD_NAME = 3'd4
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_RECORD   = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_FULL     = 3'd6
  } status_e_t;

  typedef struct packed {
    logic [PHONE_W-1:0] phone;
    logic [HEAD_W-1:0]  name_head;
    logic [TAIL_W-1:0]  name_tail;
    logic [HEAD_W-1:0]  surname_head;
    logic [TAIL_W-1:0]  surname_tail;
  } rec_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic fin;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_cmd_ok;
    logic empty;
    logic slot_free;
    logic hit;
    logic idx_zero;
  } sts_t;

  // Clears every byte after the first zero byte among bytes 0 to 7; byte 8 goes too.
  function automatic logic [STR_W-1:0] pad_str(input logic [STR_W-1:0] s);
    logic [STR_W-1:0] r;
    logic             seen;
    r    = s;
    seen = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (s[8*i +: 8] == 8'h00) seen = 1'b1;
      if (seen) r[8*i +: 8] = 8'h00;
    end
    if (seen) r[STR_W-1 -: TAIL_W] = '0;
    return r;
  endfunction

endpackage

// ===== rtl/krt_in_if.sv =====
// Command channel of the keyed record table.
interface krt_in_if import krt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [PHONE_W-1:0] phone;
  logic [HEAD_W-1:0]  name_head;
  logic [TAIL_W-1:0]  name_tail;
  logic [HEAD_W-1:0]  surname_head;
  logic [TAIL_W-1:0]  surname_tail;

  modport source (output valid, command, phone, name_head, name_tail, surname_head,
                  surname_tail, input ready);
  modport sink (input valid, command, phone, name_head, name_tail, surname_head,
                surname_tail, output ready);
endinterface

// ===== rtl/krt_out_if.sv =====
// Result channel of the keyed record table.
interface krt_out_if import krt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PHONE_W-1:0]  rec_phone;
  logic [HEAD_W-1:0]   rec_name_head;
  logic [TAIL_W-1:0]   rec_name_tail;
  logic [HEAD_W-1:0]   rec_surname_head;
  logic [TAIL_W-1:0]   rec_surname_tail;
  logic                last;

  modport source (output valid, status, rec_phone, rec_name_head, rec_name_tail,
                  rec_surname_head, rec_surname_tail, last, input ready);
  modport sink (input valid, status, rec_phone, rec_name_head, rec_name_tail,
                rec_surname_head, rec_surname_tail, last, output ready);
endinterface

// ===== rtl/krt_ctrl.sv =====
// Command sequencer: accepts an item, walks the table, then finishes the command.
module krt_ctrl import krt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          // An unknown command is taken and dropped without a result.
          if (sts.in_cmd_ok) state_nxt = sts.empty ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.slot_free) begin
          ctl.step = 1'b1;
          if (sts.hit) state_nxt = S_IDLE;
          else if (sts.idx_zero) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.slot_free) begin
          ctl.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step || ctl.fin) |-> sts.slot_free)
    else $error("table step issued while the result register is blocked");

  a_scan_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load && sts.in_cmd_ok && !sts.empty) |=> (state_r == S_SCAN))
    else $error("command on a filled table did not start a scan");

endmodule

// ===== rtl/krt_datapath.sv =====
// Record storage, key registers, entry compare and the result register.
module krt_datapath import krt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_t                ctl,
  output sts_t                sts,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [PHONE_W-1:0]  in_phone,
  input  logic [HEAD_W-1:0]   in_name_head,
  input  logic [TAIL_W-1:0]   in_name_tail,
  input  logic [HEAD_W-1:0]   in_surname_head,
  input  logic [TAIL_W-1:0]   in_surname_tail,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output rec_t                out_rec,
  output logic                out_last
);

  rec_t             entry_r [DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  cmd_e_t           cmd_r;
  rec_t             key_r;
  rec_t             pend_r;
  logic             pend_vld_r;
  logic             out_vld_r;
  status_e_t        out_status_r;
  rec_t             out_rec_r;
  logic             out_last_r;

  rec_t             cur;
  logic [STR_W-1:0] name_p, sur_p;
  logic             phone_eq, name_eq, hit, list_hit, full, slot_free;
  logic             emit, emit_last, pend_load, add_we, del_we;
  status_e_t        emit_status;
  rec_t             emit_rec;

  assign cur       = entry_r[idx_r];
  assign phone_eq  = (cur.phone == key_r.phone);
  assign name_eq   = ({cur.name_tail, cur.name_head} == {key_r.name_tail, key_r.name_head});
  assign full      = (count_r == CNT_W'(DEPTH));
  assign slot_free = !out_vld_r || out_ready;
  assign name_p    = pad_str({in_name_tail, in_name_head});
  assign sur_p     = pad_str({in_surname_tail, in_surname_head});

  always_comb begin
    hit      = 1'b0;
    list_hit = 1'b0;
    case (cmd_r) inside
      CMD_ADD, CMD_DEL, CMD_NUM: hit = phone_eq;
      CMD_LIST:                  list_hit = 1'b1;
      CMD_NAME:                  list_hit = name_eq;
      default:                   hit = 1'b0;
    endcase
  end

  assign sts.in_cmd_ok = (in_command <= CMD_W'(CMD_NAME));
  assign sts.empty     = (count_r == '0);
  assign sts.slot_free = slot_free;
  assign sts.hit       = hit;
  assign sts.idx_zero  = (idx_r == '0);

  // A listed record is held back one match so that the final one can carry last.
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_ADDED;
    emit_rec    = '0;
    emit_last   = 1'b1;
    pend_load   = 1'b0;
    add_we      = 1'b0;
    del_we      = 1'b0;
    if (ctl.step) begin
      if (hit) begin
        emit = 1'b1;
        case (cmd_r)
          CMD_ADD: emit_status = ST_DUP;
          CMD_DEL: begin
            emit_status = ST_DELETED;
            del_we      = 1'b1;
          end
          default: begin
            emit_status = ST_RECORD;
            emit_rec    = cur;
          end
        endcase
      end else if (list_hit) begin
        pend_load = 1'b1;
        if (pend_vld_r) begin
          emit        = 1'b1;
          emit_status = ST_RECORD;
          emit_rec    = pend_r;
          emit_last   = 1'b0;
        end
      end
    end else if (ctl.fin) begin
      emit = 1'b1;
      case (cmd_r) inside
        CMD_ADD: begin
          if (full) emit_status = ST_FULL;
          else begin
            emit_status = ST_ADDED;
            add_we      = 1'b1;
          end
        end
        CMD_LIST, CMD_NAME: begin
          if (pend_vld_r) begin
            emit_status = ST_RECORD;
            emit_rec    = pend_r;
          end else begin
            emit_status = (cmd_r == CMD_LIST) ? ST_EMPTY : ST_NOTFOUND;
          end
        end
        default: emit_status = ST_NOTFOUND;
      endcase
    end
  end

  // Record storage; delete closes the gap so insertion order is kept.
  always_ff @(posedge clk) begin
    if (add_we) entry_r[count_r[IDX_W-1:0]] <= key_r;
    if (del_we) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        if (IDX_W'(j) >= idx_r) entry_r[j] <= entry_r[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r.phone        <= in_phone;
      key_r.name_head    <= name_p[HEAD_W-1:0];
      key_r.name_tail    <= name_p[STR_W-1 -: TAIL_W];
      key_r.surname_head <= sur_p[HEAD_W-1:0];
      key_r.surname_tail <= sur_p[STR_W-1 -: TAIL_W];
    end
    if (pend_load) pend_r <= cur;
    if (emit) begin
      out_status_r <= emit_status;
      out_rec_r    <= emit_rec;
      out_last_r   <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      idx_r      <= '0;
      cmd_r      <= CMD_ADD;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (ctl.load) begin
        cmd_r      <= cmd_e_t'(in_command);
        idx_r      <= IDX_W'(count_r - CNT_W'(1));
        pend_vld_r <= 1'b0;
      end else if (ctl.step && !hit) begin
        idx_r <= idx_r - IDX_W'(1);
      end
      if (pend_load) pend_vld_r <= 1'b1;
      if (add_we) count_r <= count_r + CNT_W'(1);
      else if (del_we) count_r <= count_r - CNT_W'(1);
      if (emit) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_status = out_status_r;
  assign out_rec    = out_rec_r;
  assign out_last   = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fin && cmd_r == CMD_ADD && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("successful add did not grow the table");

  a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && hit && cmd_r == CMD_DEL) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("successful delete did not shrink the table");

endmodule

// ===== rtl/keyed_record_table_top.sv =====
// Keyed record table: up to DEPTH records of phone number, name and surname.
// Each command is taken in, then the stored entries are examined one at a time,
// newest first, and a closing step follows; a number match ends the scan early
// and skips the closing step.
// Throughput: one item at a time; a stalled result register holds the scan.
// Reset (synchronous, rst_n low) empties the table; record storage is not cleared.
module keyed_record_table_top import krt_pkg::*; (
  input logic clk,
  input logic rst_n,
  krt_in_if.sink   in_ch,
  krt_out_if.source out_ch
);

  ctl_t ctl;
  sts_t sts;
  rec_t out_rec;

  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  krt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_command      (in_ch.command),
    .in_phone        (in_ch.phone),
    .in_name_head    (in_ch.name_head),
    .in_name_tail    (in_ch.name_tail),
    .in_surname_head (in_ch.surname_head),
    .in_surname_tail (in_ch.surname_tail),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_rec         (out_rec),
    .out_last        (out_ch.last)
  );

  assign out_ch.rec_phone        = out_rec.phone;
  assign out_ch.rec_name_head    = out_rec.name_head;
  assign out_ch.rec_name_tail    = out_rec.name_tail;
  assign out_ch.rec_surname_head = out_rec.surname_head;
  assign out_ch.rec_surname_tail = out_rec.surname_tail;

endmodule
